[rtl/particle_box_boundary_top_defines.svh]
// Assertion macros used by the particle box boundary top level.
`ifndef PARTICLE_BOX_BOUNDARY_TOP_DEFINES_SVH
`define PARTICLE_BOX_BOUNDARY_TOP_DEFINES_SVH
// Assert that an antecedent implies a consequent in the next cycle.
`define PBB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
// Assert that an antecedent implies a consequent in the same cycle.
`define PBB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`endif

[rtl/pbb_pkg.sv]
// Package with constants and types for the particle box boundary block.
`default_nettype none
package pbb_pkg;
    localparam int COORD_BITS_DEF = 16;
    localparam int SCALE_BITS     = 16;
    localparam int PULL_BITS      = 16;
    localparam int RAND_BITS      = 16;
    localparam int NUM_AXES       = 3;
    localparam int CFG_ADDR_BITS  = 3;
    localparam int CFG_DATA_BITS  = 48;

    localparam logic [CFG_ADDR_BITS-1:0] REG_MODE       = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_BOX_MIN    = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_BOX_MAX    = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_LOW_SCALE  = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] REG_HIGH_SCALE = 3'd4;
    localparam logic [CFG_ADDR_BITS-1:0] REG_PULL       = 3'd5;
    localparam logic [CFG_ADDR_BITS-1:0] REG_KILL_Y     = 3'd6;
    localparam logic [CFG_ADDR_BITS-1:0] REG_KILL_EN    = 3'd7;

    localparam logic [1:0] MODE_PERIODIC = 2'd0;
    localparam logic [1:0] MODE_REBOUND  = 2'd1;
    localparam logic [1:0] MODE_CLAMP    = 2'd2;

    localparam logic [1:0] KIND_FLUID = 2'd0;
    localparam logic [1:0] KIND_RIGID = 2'd1;

    localparam logic [47:0] SCALE_RESET = 48'h8000_8000_8000;

    // Lane findings passed to the merge stage.
    typedef struct packed {
        logic out_lo;
        logic out_hi;
        logic hit;
    } t_lane_flags;
endpackage
`default_nettype wire

[rtl/particle_box_boundary_top.sv]
// Top level of the particle box boundary block: registers, lanes and merge.
//
// Usage: particles arrive on the input channel (i_in_valid / o_in_stall),
// one request per particle carrying kind, position, velocity and a random
// fraction. Corrected particles leave on the output channel (o_out_valid /
// i_out_stall) in the same order, one result per request.
// Three axis lanes work side by side; a merge stage ORs their crossing
// flags, decides the clamp-mode pull and computes the pull factor.
// A result passes the lane compare stage, the pull factor stage, then the
// output register before it is valid.
// Throughput is one particle per cycle; the pipeline advances whenever the
// output register is empty or being taken, so back-to-back requests flow
// without gaps.
// When the receiver stalls while a result is waiting, the whole pipeline
// holds and o_in_stall is raised, so no request is lost and the output
// payload stays stable.
// Reset clears all pipeline valid bits and loads configuration defaults:
// clamp mode, a zero box, unit face factors, a pull of one, kill check off.
// Configuration is written through i_cfg_we / i_cfg_addr / i_cfg_data while
// the block is idle; the user must keep to this, the block does not check it.
`default_nettype none
`include "particle_box_boundary_top_defines.svh"
module particle_box_boundary_top #(
    parameter int COORD_BITS = pbb_pkg::COORD_BITS_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_we,
    input  wire  [pbb_pkg::CFG_ADDR_BITS-1:0] i_cfg_addr,
    input  wire  [pbb_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    input  wire                            i_in_valid,
    output logic                           o_in_stall,
    input  wire  [1:0]                     i_kind,
    input  wire  signed [COORD_BITS-1:0]   i_pos_x,
    input  wire  signed [COORD_BITS-1:0]   i_pos_y,
    input  wire  signed [COORD_BITS-1:0]   i_pos_z,
    input  wire  signed [COORD_BITS-1:0]   i_vel_x,
    input  wire  signed [COORD_BITS-1:0]   i_vel_y,
    input  wire  signed [COORD_BITS-1:0]   i_vel_z,
    input  wire  [pbb_pkg::RAND_BITS-1:0]  i_random_fraction,
    output logic                           o_out_valid,
    input  wire                            i_out_stall,
    output logic signed [COORD_BITS-1:0]   o_new_pos_x,
    output logic signed [COORD_BITS-1:0]   o_new_pos_y,
    output logic signed [COORD_BITS-1:0]   o_new_pos_z,
    output logic signed [COORD_BITS-1:0]   o_new_vel_x,
    output logic signed [COORD_BITS-1:0]   o_new_vel_y,
    output logic signed [COORD_BITS-1:0]   o_new_vel_z,
    output logic                           o_corrected,
    output logic                           o_below_kill
);
    localparam int W  = COORD_BITS;
    localparam int N  = pbb_pkg::NUM_AXES;
    localparam int PW = COORD_BITS + pbb_pkg::SCALE_BITS + 1;

    // Configuration registers.
    logic [1:0]                    r_mode;
    logic [N*W-1:0]                r_box_min, r_box_max;
    logic [47:0]                   r_low_scale, r_high_scale;
    logic [pbb_pkg::PULL_BITS-1:0] r_pull;
    logic signed [W-1:0]           r_kill_y;
    logic                          r_kill_en;

    // Slot of a 48-bit packed register at stride W; beyond bit 63 reads zero.
    function automatic logic [W-1:0] slot_of(input logic [47:0] reg_v, input int idx);
        logic [63:0] wide;
        wide = {16'd0, reg_v};
        if (idx * W >= 64) return '0;
        return W'(wide >> (idx * W));
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= pbb_pkg::MODE_CLAMP;
            r_box_min    <= '0;
            r_box_max    <= '0;
            r_low_scale  <= pbb_pkg::SCALE_RESET;
            r_high_scale <= pbb_pkg::SCALE_RESET;
            r_pull       <= pbb_pkg::PULL_BITS'(256);
            r_kill_y     <= '0;
            r_kill_en    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                pbb_pkg::REG_MODE:       r_mode <= i_cfg_data[1:0];
                pbb_pkg::REG_BOX_MIN: begin
                    for (int a = 0; a < N; a++) r_box_min[a*W +: W] <= slot_of(i_cfg_data, a);
                end
                pbb_pkg::REG_BOX_MAX: begin
                    for (int a = 0; a < N; a++) r_box_max[a*W +: W] <= slot_of(i_cfg_data, a);
                end
                pbb_pkg::REG_LOW_SCALE:  r_low_scale <= i_cfg_data;
                pbb_pkg::REG_HIGH_SCALE: r_high_scale <= i_cfg_data;
                pbb_pkg::REG_PULL:       r_pull <= i_cfg_data[pbb_pkg::PULL_BITS-1:0];
                pbb_pkg::REG_KILL_Y:     r_kill_y <= W'(i_cfg_data);
                pbb_pkg::REG_KILL_EN:    r_kill_en <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Pipeline control: every stage advances when the output is free.
    logic r_v1, r_v2, adv;
    assign adv        = !o_out_valid || !i_out_stall;
    assign o_in_stall = !adv;

    logic signed [W-1:0] in_pos [N];
    logic signed [W-1:0] in_vel [N];
    assign in_pos = '{i_pos_x, i_pos_y, i_pos_z};
    assign in_vel = '{i_vel_x, i_vel_y, i_vel_z};

    logic signed [W-1:0]   s1_pos [N];
    logic signed [W-1:0]   s1_vel [N];
    logic signed [PW-1:0]  s1_vprod [N];
    logic                  s1_scale [N];
    pbb_pkg::t_lane_flags  s1_flags [N];

    for (genvar a = 0; a < N; a++) begin : g_lane
        pbb_lane #(.COORD_BITS(COORD_BITS)) u_lane (
            .i_clk      (i_clk),
            .i_en       (adv),
            .i_mode     (r_mode),
            .i_fluid    (i_kind == pbb_pkg::KIND_FLUID),
            .i_pos      (in_pos[a]),
            .i_vel      (in_vel[a]),
            .i_min      (r_box_min[a*W +: W]),
            .i_max      (r_box_max[a*W +: W]),
            .i_lo_scale (r_low_scale[a*16 +: 16]),
            .i_hi_scale (r_high_scale[a*16 +: 16]),
            .o_pos      (s1_pos[a]),
            .o_vel      (s1_vel[a]),
            .o_vprod    (s1_vprod[a]),
            .o_scale    (s1_scale[a]),
            .o_flags    (s1_flags[a])
        );
    end

    // Stage 1 side registers.
    logic                           r_fluid1, r_kill1;
    logic [1:0]                     r_mode1;
    logic [pbb_pkg::RAND_BITS-1:0]  r_rand1;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_fluid1 <= i_kind == pbb_pkg::KIND_FLUID;
            r_mode1  <= r_mode;
            r_rand1  <= i_random_fraction;
            r_kill1  <= r_kill_en && (i_kind == pbb_pkg::KIND_RIGID) && (i_pos_y < r_kill_y);
        end
    end

    // Merge: OR lane hits, decide pull, compute pull factor t.
    logic any_hit;
    logic [2*pbb_pkg::PULL_BITS-1:0] t_full;
    always_comb begin
        any_hit = 1'b0;
        for (int a = 0; a < N; a++) any_hit = any_hit | s1_flags[a].hit;
        any_hit = any_hit && r_fluid1;
        t_full  = r_rand1 * r_pull;
    end

    logic signed [W-1:0]  r2_pos [N];
    logic signed [W-1:0]  r2_vel [N];
    logic signed [PW-1:0] r2_vprod [N];
    logic                 r2_scale [N];
    logic                 r_hit2, r_pull2, r_kill2;
    logic [pbb_pkg::PULL_BITS-1:0] r_t2;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int a = 0; a < N; a++) begin
                r2_pos[a]   <= s1_pos[a];
                r2_vel[a]   <= s1_vel[a];
                r2_vprod[a] <= s1_vprod[a];
                r2_scale[a] <= s1_scale[a] && r_fluid1;
            end
            r_hit2  <= any_hit;
            r_pull2 <= any_hit && (r_mode1 != pbb_pkg::MODE_PERIODIC)
                               && (r_mode1 != pbb_pkg::MODE_REBOUND);
            r_t2    <= t_full[2*pbb_pkg::PULL_BITS-1 -: pbb_pkg::PULL_BITS];
            r_kill2 <= r_kill1;
        end
    end

    logic signed [W-1:0] f_pos [N];
    logic signed [W-1:0] f_vel [N];
    for (genvar a = 0; a < N; a++) begin : g_fin
        pbb_finish #(.COORD_BITS(COORD_BITS)) u_fin (
            .i_pull_on (r_pull2),
            .i_t       (r_t2),
            .i_pos     (r2_pos[a]),
            .i_vel     (r2_vel[a]),
            .i_vprod   (r2_vprod[a]),
            .i_scale   (r2_scale[a]),
            .i_min     (r_box_min[a*W +: W]),
            .i_max     (r_box_max[a*W +: W]),
            .o_pos     (f_pos[a]),
            .o_vel     (f_vel[a])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            o_out_valid <= 1'b0;
        end else if (adv) begin
            r_v1        <= i_in_valid;
            r_v2        <= r_v1;
            o_out_valid <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            o_new_pos_x  <= f_pos[0];
            o_new_pos_y  <= f_pos[1];
            o_new_pos_z  <= f_pos[2];
            o_new_vel_x  <= f_vel[0];
            o_new_vel_y  <= f_vel[1];
            o_new_vel_z  <= f_vel[2];
            o_corrected  <= r_hit2;
            o_below_kill <= r_kill2;
        end
    end

    // A stalled result must stay valid.
    `PBB_ASSERT_NEXT(a_hold_valid, i_clk, i_rst_n, o_out_valid && i_out_stall,
                     o_out_valid, "result dropped under stall")
    // Input stall follows output stall with a full output register.
    `PBB_ASSERT_NOW(a_stall_src, i_clk, i_rst_n, o_in_stall,
                    o_out_valid && i_out_stall, "spurious input stall")
    // Pull only happens on a corrected particle.
    `PBB_ASSERT_NOW(a_pull_hit, i_clk, i_rst_n, r_pull2, r_hit2,
                    "pull without boundary hit")
endmodule
`default_nettype wire

[rtl/pbb_lane.sv]
// One axis lane: first stage of the box rule (compare, wrap, mirror, clamp).
`default_nettype none
module pbb_lane #(
    parameter int COORD_BITS = pbb_pkg::COORD_BITS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_en,
    input  wire  [1:0]                   i_mode,
    input  wire                          i_fluid,
    input  wire  signed [COORD_BITS-1:0] i_pos,
    input  wire  signed [COORD_BITS-1:0] i_vel,
    input  wire  signed [COORD_BITS-1:0] i_min,
    input  wire  signed [COORD_BITS-1:0] i_max,
    input  wire  [pbb_pkg::SCALE_BITS-1:0] i_lo_scale,
    input  wire  [pbb_pkg::SCALE_BITS-1:0] i_hi_scale,
    output logic signed [COORD_BITS-1:0] o_pos,
    output logic signed [COORD_BITS-1:0] o_vel,
    output logic signed [COORD_BITS+pbb_pkg::SCALE_BITS:0] o_vprod,
    output logic                         o_scale,
    output pbb_pkg::t_lane_flags         o_flags
);
    localparam int W  = COORD_BITS;
    localparam int PW = COORD_BITS + pbb_pkg::SCALE_BITS + 1;
    localparam logic signed [W+1:0] SMAX = (W+2)'((64'sd1 <<< (W-1)) - 1);
    localparam logic signed [W+1:0] SMIN = -SMAX - (W+2)'(1);

    logic                   lo, hi, lo2, hi2;
    logic signed [W+1:0]    span, wrap, mir;
    logic signed [W-1:0]    n_pos, n_vel;
    logic signed [W+1:0]    n_mir;
    logic signed [PW-1:0]   n_vprod;
    logic [pbb_pkg::SCALE_BITS-1:0] fac;

    always_comb begin
        lo   = i_pos < i_min;
        hi   = !lo && (i_pos > i_max);
        span = (W+2)'(i_max) - (W+2)'(i_min);
        wrap = lo ? (W+2)'(i_pos) + span : (hi ? (W+2)'(i_pos) - span : (W+2)'(i_pos));
        lo2  = wrap < (W+2)'(i_min);
        hi2  = !lo2 && (wrap > (W+2)'(i_max));
        mir  = lo ? ((W+2)'(i_min) <<< 1) - (W+2)'(i_pos)
                  : ((W+2)'(i_max) <<< 1) - (W+2)'(i_pos);
        n_mir = mir;
        if (mir > SMAX)      n_mir = SMAX;
        else if (mir < SMIN) n_mir = SMIN;
        fac     = lo ? i_lo_scale : i_hi_scale;
        n_vprod = PW'(i_vel) * $signed({1'b0, fac});
        n_pos   = i_pos;
        n_vel   = i_vel;
        // Only fluid particles follow the box rule; other kinds pass through.
        if (i_fluid) begin
            case (i_mode)
                pbb_pkg::MODE_PERIODIC: begin
                    if (lo2)      n_pos = i_min;
                    else if (hi2) n_pos = i_max;
                    else          n_pos = W'(wrap);
                end
                pbb_pkg::MODE_REBOUND: begin
                    if (lo || hi) begin
                        n_pos = W'(n_mir);
                        n_vel = (i_vel == W'(SMIN)) ? W'(SMAX) : -i_vel;
                    end
                end
                default: begin
                    if (lo)      n_pos = i_min;
                    else if (hi) n_pos = i_max;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_pos      <= n_pos;
            o_vel      <= n_vel;
            o_vprod    <= n_vprod;
            o_scale    <= (i_mode == pbb_pkg::MODE_PERIODIC) && (lo || hi);
            o_flags    <= '{out_lo: lo, out_hi: hi, hit: lo || hi};
        end
    end
endmodule
`default_nettype wire

[rtl/pbb_finish.sv]
// One axis second stage: velocity rounding and clamp-mode pull toward center.
`default_nettype none
module pbb_finish #(
    parameter int COORD_BITS = pbb_pkg::COORD_BITS_DEF
) (
    input  wire                          i_pull_on,
    input  wire  [pbb_pkg::PULL_BITS-1:0] i_t,
    input  wire  signed [COORD_BITS-1:0] i_pos,
    input  wire  signed [COORD_BITS-1:0] i_vel,
    input  wire  signed [COORD_BITS+pbb_pkg::SCALE_BITS:0] i_vprod,
    input  wire                          i_scale,
    input  wire  signed [COORD_BITS-1:0] i_min,
    input  wire  signed [COORD_BITS-1:0] i_max,
    output logic signed [COORD_BITS-1:0] o_pos,
    output logic signed [COORD_BITS-1:0] o_vel
);
    localparam int W  = COORD_BITS;
    localparam int PW = COORD_BITS + pbb_pkg::SCALE_BITS + 1;
    localparam int MW = W + 2 + pbb_pkg::PULL_BITS + 1;
    localparam logic signed [MW-1:0] SMAX = MW'((64'sd1 <<< (W-1)) - 1);
    localparam logic signed [MW-1:0] SMIN = -SMAX - MW'(1);

    logic signed [PW:0]   vr;
    logic signed [MW-1:0] vs, ctr, diff, prod, np;

    always_comb begin
        vr = ((PW+1)'(i_vprod) + (PW+1)'(16384)) >>> 15;
        vs = MW'(vr);
        if (vs > SMAX)      vs = SMAX;
        else if (vs < SMIN) vs = SMIN;
        ctr  = (MW'(i_min) + MW'(i_max)) >>> 1;
        diff = ctr - MW'(i_pos);
        prod = diff * $signed({1'b0, i_t});
        np   = MW'(i_pos) + ((prod + MW'(128)) >>> 8);
        if (np > SMAX)      np = SMAX;
        else if (np < SMIN) np = SMIN;
        o_pos = i_pull_on ? W'(np) : i_pos;
        o_vel = i_pull_on ? '0 : (i_scale ? W'(vs) : i_vel);
    end
endmodule
`default_nettype wire

[dv/tb.sv]
// Self-checking testbench for the particle box boundary block.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = pbb_pkg::COORD_BITS_DEF;
    localparam int LIMIT_CYCLES = 400000;
    localparam logic [1:0] KIND_STATIC = 2'd2;
    localparam logic [1:0] KIND_SPARE  = 2'd3;
    localparam logic [1:0] MODE_SPARE  = 2'd3;

    // One particle as it leaves the block.
    typedef struct {
        logic signed [CW-1:0] pos [3];
        logic signed [CW-1:0] vel [3];
        logic                 corrected;
        logic                 below_kill;
    } t_particle_out;

    // Holds the predicted particles in order and compares arrivals with them.
    class particle_scoreboard;
        t_particle_out pending [$];
        int            mismatches;

        function void note_request(t_particle_out exp_p);
            pending.push_back(exp_p);
        endfunction

        function void check_result(t_particle_out got);
            t_particle_out exp_p;
            bit bad;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result pos %0d %0d %0d", got.pos[0], got.pos[1],
                             got.pos[2]);
                return;
            end
            exp_p = pending.pop_front();
            bad = 0;
            for (int a = 0; a < 3; a++) begin
                if (got.pos[a] !== exp_p.pos[a] || got.vel[a] !== exp_p.vel[a])
                    bad = 1;
            end
            if (got.corrected !== exp_p.corrected || got.below_kill !== exp_p.below_kill)
                bad = 1;
            if (bad) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: exp pos %0d %0d %0d vel %0d %0d %0d c%0b k%0b,",
                              " got pos %0d %0d %0d vel %0d %0d %0d c%0b k%0b"},
                             exp_p.pos[0], exp_p.pos[1], exp_p.pos[2],
                             exp_p.vel[0], exp_p.vel[1], exp_p.vel[2],
                             exp_p.corrected, exp_p.below_kill,
                             got.pos[0], got.pos[1], got.pos[2],
                             got.vel[0], got.vel[1], got.vel[2],
                             got.corrected, got.below_kill);
            end
        endfunction
    endclass

    logic                     i_clk = 0;
    logic                     i_rst_n = 0;
    logic                     i_cfg_we = 0;
    logic [pbb_pkg::CFG_ADDR_BITS-1:0] i_cfg_addr = '0;
    logic [pbb_pkg::CFG_DATA_BITS-1:0] i_cfg_data = '0;
    logic                     i_in_valid = 0;
    logic                     o_in_stall;
    logic [1:0]               i_kind = '0;
    logic signed [CW-1:0]     i_pos_x = '0, i_pos_y = '0, i_pos_z = '0;
    logic signed [CW-1:0]     i_vel_x = '0, i_vel_y = '0, i_vel_z = '0;
    logic [pbb_pkg::RAND_BITS-1:0] i_random_fraction = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 0;
    logic signed [CW-1:0]     o_new_pos_x, o_new_pos_y, o_new_pos_z;
    logic signed [CW-1:0]     o_new_vel_x, o_new_vel_y, o_new_vel_z;
    logic                     o_corrected, o_below_kill;

    particle_box_boundary_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_kind(i_kind),
        .i_pos_x(i_pos_x), .i_pos_y(i_pos_y), .i_pos_z(i_pos_z),
        .i_vel_x(i_vel_x), .i_vel_y(i_vel_y), .i_vel_z(i_vel_z),
        .i_random_fraction(i_random_fraction),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_new_pos_x(o_new_pos_x), .o_new_pos_y(o_new_pos_y),
        .o_new_pos_z(o_new_pos_z), .o_new_vel_x(o_new_vel_x),
        .o_new_vel_y(o_new_vel_y), .o_new_vel_z(o_new_vel_z),
        .o_corrected(o_corrected), .o_below_kill(o_below_kill)
    );

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    // Shadow copy of the configuration registers, used by the predictor.
    logic [1:0]  cfg_mode;
    logic [47:0] cfg_box_min, cfg_box_max, cfg_low_scale, cfg_high_scale;
    logic [15:0] cfg_pull;
    logic signed [CW-1:0] cfg_kill_y;
    logic        cfg_kill_en;

    particle_scoreboard board;
    int  sender_idle_pct;
    int  receiver_stall_pct;
    bit  hold_receiver;      // long hold-off on the output side
    int  cycle_count = 0;

    function automatic longint sat_coord(longint x);
        longint hi, lo;
        hi = (longint'(1) <<< (CW - 1)) - 1;
        lo = -hi - 1;
        return x < lo ? lo : (x > hi ? hi : x);
    endfunction

    // Arithmetic right shift of a signed value rounds toward minus infinity.
    function automatic longint scale_velocity(longint v, logic [15:0] f);
        return sat_coord((v * longint'({1'b0, f}) + 16384) >>> 15);
    endfunction

    // Applies the box rule to one particle under the shadow configuration.
    function automatic t_particle_out apply_box_rule(logic [1:0] kind,
            logic signed [CW-1:0] pin [3], logic signed [CW-1:0] vin [3],
            logic [15:0] rnd);
        t_particle_out r;
        longint p [3], v [3], mn [3], mx [3];
        longint t, c;
        bit hit;
        hit = 0;
        for (int a = 0; a < 3; a++) begin
            p[a] = pin[a];
            v[a] = vin[a];
            mn[a] = longint'($signed(cfg_box_min[a*CW +: CW]));
            mx[a] = longint'($signed(cfg_box_max[a*CW +: CW]));
        end
        r.below_kill = cfg_kill_en && kind == pbb_pkg::KIND_RIGID && pin[1] < cfg_kill_y;
        if (kind == pbb_pkg::KIND_FLUID) begin
            if (cfg_mode == pbb_pkg::MODE_PERIODIC) begin
                for (int a = 0; a < 3; a++) begin
                    if (p[a] < mn[a]) begin
                        p[a] += mx[a] - mn[a];
                        v[a] = scale_velocity(v[a], cfg_low_scale[a*16 +: 16]);
                        hit = 1;
                    end else if (p[a] > mx[a]) begin
                        p[a] -= mx[a] - mn[a];
                        v[a] = scale_velocity(v[a], cfg_high_scale[a*16 +: 16]);
                        hit = 1;
                    end
                    if (p[a] < mn[a]) p[a] = mn[a];
                    else if (p[a] > mx[a]) p[a] = mx[a];
                end
            end else if (cfg_mode == pbb_pkg::MODE_REBOUND) begin
                for (int a = 0; a < 3; a++) begin
                    if (p[a] < mn[a]) begin
                        p[a] = sat_coord(2 * mn[a] - p[a]);
                        v[a] = sat_coord(-v[a]);
                        hit = 1;
                    end else if (p[a] > mx[a]) begin
                        p[a] = sat_coord(2 * mx[a] - p[a]);
                        v[a] = sat_coord(-v[a]);
                        hit = 1;
                    end
                end
            end else begin
                for (int a = 0; a < 3; a++) begin
                    if (p[a] < mn[a]) begin
                        p[a] = mn[a];
                        hit = 1;
                    end else if (p[a] > mx[a]) begin
                        p[a] = mx[a];
                        hit = 1;
                    end
                end
                if (hit) begin
                    t = (longint'(rnd) * longint'(cfg_pull)) >>> 16;
                    for (int a = 0; a < 3; a++) begin
                        c = (mn[a] + mx[a]) >>> 1;
                        p[a] = sat_coord(p[a] + (((c - p[a]) * t + 128) >>> 8));
                        v[a] = 0;
                    end
                end
            end
        end
        for (int a = 0; a < 3; a++) begin
            r.pos[a] = p[a][CW-1:0];
            r.vel[a] = v[a][CW-1:0];
        end
        r.corrected = hit;
        return r;
    endfunction

    task automatic write_reg(logic [pbb_pkg::CFG_ADDR_BITS-1:0] idx, longint val);
        logic [47:0] v;
        v = 48'(val);
        i_cfg_we   <= 1;
        i_cfg_addr <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 0;
        case (idx)
            pbb_pkg::REG_MODE:       cfg_mode = v[1:0];
            pbb_pkg::REG_BOX_MIN:    cfg_box_min = v;
            pbb_pkg::REG_BOX_MAX:    cfg_box_max = v;
            pbb_pkg::REG_LOW_SCALE:  cfg_low_scale = v;
            pbb_pkg::REG_HIGH_SCALE: cfg_high_scale = v;
            pbb_pkg::REG_PULL:       cfg_pull = v[15:0];
            pbb_pkg::REG_KILL_Y:     cfg_kill_y = v[CW-1:0];
            default:                 cfg_kill_en = v[0];
        endcase
    endtask

    function automatic logic [47:0] pack3(int x, int y, int z);
        return {z[15:0], y[15:0], x[15:0]};
    endfunction

    // Offers one request, holding the payload until the block takes it.
    task automatic send_particle(int kind, int px, int py, int pz,
            int vx, int vy, int vz, int rnd);
        logic [1:0]           k;
        logic [15:0]          rf;
        logic signed [CW-1:0] pin [3];
        logic signed [CW-1:0] vin [3];
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 0;
            @(posedge i_clk);
        end
        k   = 2'(kind);
        rf  = 16'(rnd);
        pin = '{CW'(px), CW'(py), CW'(pz)};
        vin = '{CW'(vx), CW'(vy), CW'(vz)};
        i_in_valid <= 1;
        i_kind <= k;
        i_pos_x <= pin[0]; i_pos_y <= pin[1]; i_pos_z <= pin[2];
        i_vel_x <= vin[0]; i_vel_y <= vin[1]; i_vel_z <= vin[2];
        i_random_fraction <= rf;
        do @(posedge i_clk); while (o_in_stall);
        board.note_request(apply_box_rule(k, pin, vin, rf));
    endtask

    task automatic stop_sending();
        i_in_valid <= 0;
    endtask

    // Waits until every predicted particle has come back, then lets the
    // pipeline drain before touching registers.
    task automatic wait_drained();
        stop_sending();
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    // Random coordinate: mostly near the box, sometimes anywhere.
    function automatic int rand_coord();
        case ($urandom_range(3))
            0: return int'($urandom);
            1: return $urandom_range(1) ? 32767 : -32768;
            default: return int'($urandom_range(2048)) - 1024;
        endcase
    endfunction

    task automatic send_random(int count);
        for (int n = 0; n < count; n++)
            send_particle(int'($urandom_range(3)), rand_coord(), rand_coord(), rand_coord(),
                          int'($urandom), int'($urandom), int'($urandom), int'($urandom));
    endtask

    // Receiver: stall at random, hold off completely while asked to, and check each result taken.
    always @(posedge i_clk) begin
        i_out_stall <= hold_receiver || ($urandom_range(99) < receiver_stall_pct);
        if (i_rst_n && o_out_valid && !i_out_stall)
            board.check_result('{pos: '{o_new_pos_x, o_new_pos_y, o_new_pos_z},
                                 vel: '{o_new_vel_x, o_new_vel_y, o_new_vel_z},
                                 corrected: o_corrected, below_kill: o_below_kill});
    end

    // Hard cycle limit against a hung handshake.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        board = new();
        hold_receiver = 0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        // Mirror of the reset values of the configuration registers.
        cfg_mode = pbb_pkg::MODE_CLAMP;
        cfg_box_min = '0;
        cfg_box_max = '0;
        cfg_low_scale = pbb_pkg::SCALE_RESET;
        cfg_high_scale = pbb_pkg::SCALE_RESET;
        cfg_pull = 16'd256;
        cfg_kill_y = '0;
        cfg_kill_en = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed part under reset values: zero box, clamp, fluid, rigid and spare kinds.
        send_particle(pbb_pkg::KIND_FLUID, 16'sh7fff, 16'sh8000, 0, 16'sh7fff, 16'sh8000,
                      1, 16'hffff);
        send_particle(KIND_SPARE, 16'sh8000, 16'sh7fff, 5, 1, 2, 3, 0);
        send_particle(pbb_pkg::KIND_RIGID, -5, -5, 0, 9, 9, 9, 0);
        wait_drained();

        // Configure a normal box, the pull and the kill check.
        write_reg(pbb_pkg::REG_BOX_MIN, pack3(-256, -512, -1024));
        write_reg(pbb_pkg::REG_BOX_MAX, pack3(256, 512, 1024));
        write_reg(pbb_pkg::REG_KILL_Y, 48'(16'(-100)));
        write_reg(pbb_pkg::REG_KILL_EN, 1);
        write_reg(pbb_pkg::REG_PULL, 16'hffff);
        send_particle(pbb_pkg::KIND_FLUID, -300, 600, 0, 100, -100, 7, 16'hffff);
        send_particle(pbb_pkg::KIND_FLUID, 0, 0, 0, 100, -100, 7, 16'h8000);
        send_particle(pbb_pkg::KIND_RIGID, 0, -101, 0, 1, 1, 1, 0);
        send_particle(pbb_pkg::KIND_RIGID, 0, -100, 0, 1, 1, 1, 0);
        send_particle(KIND_STATIC, 16'sh8000, -200, 16'sh7fff, 1, 1, 1, 0);
        wait_drained();

        // Periodic, with extreme face factors, including a far-off particle.
        write_reg(pbb_pkg::REG_MODE, pbb_pkg::MODE_PERIODIC);
        write_reg(pbb_pkg::REG_LOW_SCALE, 48'hffff_0000_8001);
        write_reg(pbb_pkg::REG_HIGH_SCALE, 48'h0000_ffff_4000);
        send_particle(pbb_pkg::KIND_FLUID, -257, 513, 16'sh8000, 16'sh8000, 16'sh7fff, -3, 0);
        send_particle(pbb_pkg::KIND_FLUID, 257, -513, 16'sh7fff, 16'sh7fff, 16'sh8000, 3, 0);
        send_particle(pbb_pkg::KIND_FLUID, 256, -512, 1024, 5, 5, 5, 0);
        wait_drained();

        // Rebound, with faces at the coordinate extremes to force saturation.
        write_reg(pbb_pkg::REG_MODE, pbb_pkg::MODE_REBOUND);
        write_reg(pbb_pkg::REG_BOX_MIN, pack3(32767, -32768, -1));
        write_reg(pbb_pkg::REG_BOX_MAX, pack3(32767, -32768, 1));
        send_particle(pbb_pkg::KIND_FLUID, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000,
                      16'sh8000, 16'sh7fff, 0);
        send_particle(pbb_pkg::KIND_FLUID, 0, 0, 2, 0, 0, 1, 0);
        wait_drained();

        // Unused mode three acts as clamp; inverted box.
        write_reg(pbb_pkg::REG_MODE, MODE_SPARE);
        write_reg(pbb_pkg::REG_BOX_MIN, pack3(100, 100, 100));
        write_reg(pbb_pkg::REG_BOX_MAX, pack3(-100, -100, -100));
        send_particle(pbb_pkg::KIND_FLUID, 0, 200, -200, 1, 2, 3, 16'h1234);
        send_particle(pbb_pkg::KIND_FLUID, 150, 0, 0, 1, 2, 3, 16'hffff);
        wait_drained();

        // Random phases over several settings and idling patterns.
        for (int ph = 0; ph < 16; ph++) begin
            write_reg(pbb_pkg::REG_MODE, ph % 4);
            if (ph % 5 == 4) begin
                write_reg(pbb_pkg::REG_BOX_MIN, {$urandom, $urandom});
                write_reg(pbb_pkg::REG_BOX_MAX, {$urandom, $urandom});
            end else begin
                write_reg(pbb_pkg::REG_BOX_MIN, pack3(-$urandom_range(1500),
                                                      -$urandom_range(1500),
                                                      -$urandom_range(1500)));
                write_reg(pbb_pkg::REG_BOX_MAX, pack3($urandom_range(1500),
                                                      $urandom_range(1500),
                                                      $urandom_range(1500)));
            end
            write_reg(pbb_pkg::REG_LOW_SCALE, {$urandom, $urandom});
            write_reg(pbb_pkg::REG_HIGH_SCALE,
                      ph == 15 ? 64'h0000_ffff_ffff_ffff : {$urandom, $urandom});
            write_reg(pbb_pkg::REG_PULL, ph == 14 ? 16'h0 : 16'($urandom));
            write_reg(pbb_pkg::REG_KILL_Y, $urandom);
            write_reg(pbb_pkg::REG_KILL_EN, $urandom_range(1));
            case (ph % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 56; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 56; end
                default: begin sender_idle_pct = 27; receiver_stall_pct = 27; end
            endcase
            if (ph == 5) begin
                // The receiver holds off long enough for the block to fill and
                // stall its input while requests keep coming.
                fork
                    begin
                        hold_receiver = 1;
                        repeat (60) @(posedge i_clk);
                        hold_receiver = 0;
                    end
                    send_random(68);
                join
            end else begin
                send_random(34);
                // The sender pauses until everything outstanding has come back.
                stop_sending();
                while (board.pending.size() != 0) @(posedge i_clk);
                send_random(34);
            end
            wait_drained();
        end

        stop_sending();
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (board.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
`default_nettype wire

[filelist.f]
+incdir+rtl
rtl/pbb_pkg.sv
rtl/pbb_lane.sv
rtl/pbb_finish.sv
rtl/particle_box_boundary_top.sv
dv/tb.sv
